>>> rtl/core/mpfb_pkg.sv
package mpfb_pkg;

    localparam int COLUMNS = 128;
    localparam int ROWS    = 64;
    localparam int PAGES   = (ROWS + 7) / 8;
    localparam int DEPTH   = PAGES * COLUMNS;

    localparam int XW = $clog2(COLUMNS);
    localparam int YW = $clog2(ROWS);
    localparam int AW = $clog2(DEPTH);

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QW     = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        CMD_WRITE_PIXEL  = 3'd0,
        CMD_INVERT_PIXEL = 3'd1,
        CMD_HLINE        = 3'd2,
        CMD_VLINE        = 3'd3,
        CMD_INVERT_RECT  = 3'd4,
        CMD_CLEAR        = 3'd5,
        CMD_READ_BYTE    = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_DRAW,
        KIND_CLEAR,
        KIND_READ
    } t_kind;

    typedef enum logic [1:0] {
        MODE_CLR,
        MODE_SET,
        MODE_FLIP
    } t_mode;

    typedef struct packed {
        t_kind           kind;
        t_mode           mode;
        logic            mirror;
        logic [XW-1:0]   x0;
        logic [XW-1:0]   x1;
        logic [YW-1:0]   y0;
        logic [YW-1:0]   y1;
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/mpfb_ram.sv
module mpfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mpfb_front.sv
module mpfb_front
    import mpfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_hold,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_span_len,
    input  logic [7:0] i_span_height,
    input  logic       i_fill,
    output logic       o_valid,
    output t_op        o_op,
    input  logic       i_take
);

    t_op            c_op;
    logic           c_draw;
    logic           c_clear;
    logic           c_read;
    t_mode          c_mode;
    logic           c_mirror;
    logic [7:0]     c_len;
    logic [7:0]     c_hgt;
    logic [8:0]     c_x_end;
    logic [8:0]     c_y_end;
    logic           c_x_on;
    logic           c_y_on;
    logic           c_accept;

    t_op            r_q [QDEPTH];
    logic [QW-1:0]  r_wr_ptr;
    logic [QW-1:0]  r_rd_ptr;
    logic [QCW-1:0] r_count;

    // Every drawing command becomes a clipped rectangle of pixels.
    always_comb begin
        c_draw   = 1'b0;
        c_clear  = 1'b0;
        c_read   = 1'b0;
        c_mode   = i_fill ? MODE_SET : MODE_CLR;
        c_mirror = 1'b0;
        c_len    = 8'd1;
        c_hgt    = 8'd1;
        unique case (i_cmd)
            CMD_WRITE_PIXEL: begin
                c_draw = 1'b1;
            end
            CMD_INVERT_PIXEL: begin
                c_draw   = 1'b1;
                c_mode   = MODE_FLIP;
                c_mirror = 1'b1;
            end
            CMD_HLINE: begin
                c_draw = 1'b1;
                c_len  = i_span_len;
            end
            CMD_VLINE: begin
                c_draw = 1'b1;
                c_hgt  = i_span_len;
            end
            CMD_INVERT_RECT: begin
                c_draw   = 1'b1;
                c_mode   = MODE_FLIP;
                c_mirror = 1'b1;
                c_len    = i_span_len;
                c_hgt    = i_span_height;
            end
            CMD_CLEAR: begin
                c_clear = 1'b1;
            end
            CMD_READ_BYTE: begin
                c_read = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        c_x_on  = {1'b0, i_pos_x} < 9'(COLUMNS);
        c_y_on  = {1'b0, i_pos_y} < 9'(ROWS);
        c_x_end = {1'b0, i_pos_x} + {1'b0, c_len} - 9'd1;
        c_y_end = {1'b0, i_pos_y} + {1'b0, c_hgt} - 9'd1;

        c_op.mode   = c_mode;
        c_op.mirror = c_mirror;
        c_op.x0     = i_pos_x[XW-1:0];
        c_op.y0     = i_pos_y[YW-1:0];
        c_op.x1     = (c_x_end >= 9'(COLUMNS)) ? XW'(COLUMNS - 1) : c_x_end[XW-1:0];
        c_op.y1     = (c_y_end >= 9'(ROWS)) ? YW'(ROWS - 1) : c_y_end[YW-1:0];

        priority if (c_clear) begin
            c_op.kind = KIND_CLEAR;
        end else if (c_read && c_x_on && c_y_on) begin
            c_op.kind = KIND_READ;
        end else if (c_draw && c_x_on && c_y_on && c_len != 8'd0 && c_hgt != 8'd0) begin
            c_op.kind = KIND_DRAW;
        end else begin
            c_op.kind = KIND_NOP;
        end
    end

    assign full     = (r_count == QCW'(QDEPTH)) || i_hold;
    assign c_accept = push && !full;
    assign o_valid  = r_count != '0;
    assign o_op     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_q[r_wr_ptr] <= c_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (c_accept) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_take && o_valid) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (c_accept && !(i_take && o_valid)) begin
                r_count <= r_count + 1'b1;
            end else if (!c_accept && i_take && o_valid) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/mpfb_back.sv
module mpfb_back
    import mpfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_op        i_op,
    output logic       o_take,
    output logic       o_init,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_read_data
);

    t_state         r_state;
    t_state         n_state;
    t_op            r_op;
    logic [XW-1:0]  r_cur_x;
    logic [YW-1:0]  r_cur_y;
    logic [AW-1:0]  r_cnt;
    logic [7:0]     r_rd_data;
    logic           r_res_valid;
    logic [7:0]     r_res_data;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    logic [XW-1:0]  pix_x;
    logic [AW-1:0]  pix_addr;
    logic [7:0]     pix_mask;
    logic [7:0]     pix_byte;
    logic           last_pix;
    logic           last_cnt;
    logic           res_room;
    logic           res_load;

    mpfb_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Invert commands touch the mirrored column.
    always_comb begin
        pix_x    = r_op.mirror ? XW'(COLUMNS - 1) - r_cur_x : r_cur_x;
        pix_addr = AW'(AW'(r_cur_y >> 3) * AW'(COLUMNS) + AW'(pix_x));
        pix_mask = 8'b1 << r_cur_y[2:0];
        unique case (r_op.mode)
            MODE_SET:  pix_byte = ram_rdata | pix_mask;
            MODE_FLIP: pix_byte = ram_rdata ^ pix_mask;
            default:   pix_byte = ram_rdata & ~pix_mask;
        endcase
        last_pix = (r_cur_x == r_op.x1) && (r_cur_y == r_op.y1);
        last_cnt = r_cnt == AW'(DEPTH - 1);
        res_room = !r_res_valid || pop;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (last_cnt) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_op.kind)
                        KIND_CLEAR: n_state = ST_CLEAR;
                        KIND_DRAW:  n_state = ST_RD;
                        KIND_READ:  n_state = ST_RD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (r_op.kind != KIND_DRAW || last_pix) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_CLEAR: begin
                if (last_cnt) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_room) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = pix_byte;
        ram_raddr = pix_addr;
        o_take    = 1'b0;
        o_init    = 1'b0;
        res_load  = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_init    = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = 8'd0;
            end
            ST_IDLE: begin
                o_take = i_valid;
            end
            ST_WR: begin
                ram_we = r_op.kind == KIND_DRAW;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = 8'd0;
            end
            ST_DONE: begin
                res_load = res_room;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_op      <= i_op;
            r_cur_x   <= i_op.x0;
            r_cur_y   <= i_op.y0;
            r_rd_data <= 8'd0;
        end
        if (r_state == ST_WR && r_op.kind == KIND_READ) begin
            r_rd_data <= ram_rdata;
        end
        // Rows run inside columns; the rectangle was clipped by the front.
        if (r_state == ST_WR && r_op.kind == KIND_DRAW && !last_pix) begin
            if (r_cur_y == r_op.y1) begin
                r_cur_y <= r_op.y0;
                r_cur_x <= r_cur_x + 1'b1;
            end else begin
                r_cur_y <= r_cur_y + 1'b1;
            end
        end
        if (res_load) begin
            r_res_data <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_take) begin
                r_cnt <= '0;
            end else if (r_state == ST_INIT || r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign empty       = !r_res_valid;
    assign o_read_data = r_res_data;

`ifndef SYNTHESIS
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !pop |=> r_res_valid && $stable(r_res_data))
        else $error("result beat changed before it was taken");

    a_rd_then_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD |=> r_state == ST_WR)
        else $error("read of the store not followed by its write stage");

    a_draw_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WR && r_op.kind == KIND_DRAW |->
        r_cur_x <= r_op.x1 && r_cur_y <= r_op.y1 && r_cur_y >= r_op.y0)
        else $error("drawn pixel outside the clipped rectangle");

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> int'(ram_waddr) < DEPTH)
        else $error("write beyond the frame store");
`endif

endmodule

>>> rtl/core/mono_page_framebuffer_draw.sv
// Channel   Direction  Handshake        Beat contents
// command   in         push / full      cmd, pos_x, pos_y, span_len, span_height, fill
// result    out        empty / pop      read_data (byte for a read, else zero)
//
// A pixel command passes through four back-end states: idle, store read, write, result.
// Lines and rectangles visit each on-screen pixel with one store read and one write,
// stepping rows inside columns.
// Clear sweeps the store one byte a cycle: 1024 bytes at 128 by 64.
// After reset the same sweep runs over the whole store while full stays high.
// A two-deep command queue keeps taking commands while a result waits for pop.
module mono_page_framebuffer_draw
    import mpfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_span_len,
    input  logic [7:0] i_span_height,
    input  logic       i_fill,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_read_data
);

    logic op_valid;
    t_op  op;
    logic op_take;
    logic init;

    mpfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (init),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_span_len    (i_span_len),
        .i_span_height (i_span_height),
        .i_fill        (i_fill),
        .o_valid       (op_valid),
        .o_op          (op),
        .i_take        (op_take)
    );

    mpfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (op_valid),
        .i_op        (op),
        .o_take      (op_take),
        .o_init      (init),
        .empty       (empty),
        .pop         (pop),
        .o_read_data (o_read_data)
    );

endmodule

>>> dv/tb_mono_page_framebuffer_draw.sv
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_draw
    import mpfb_pkg::*;
();

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 2_000_000;

    class fb_scoreboard;
        logic [7:0] pix_bytes [DEPTH];
        logic [7:0] byte_q [$];
        int errors;

        function new();
            foreach (pix_bytes[k]) pix_bytes[k] = 8'h00;
            errors = 0;
        endfunction

        function void paint_pixel(int x, int y, bit f);
            int idx;
            if (x >= COLUMNS || y >= ROWS) return;
            idx = (y / 8) * COLUMNS + x;
            if (f) pix_bytes[idx] = pix_bytes[idx] | (8'h01 << (y % 8));
            else   pix_bytes[idx] = pix_bytes[idx] & ~(8'h01 << (y % 8));
        endfunction

        // Invert commands touch the mirrored column.
        function void flip_pixel(int x, int y);
            int idx;
            if (x >= COLUMNS || y >= ROWS) return;
            idx = (y / 8) * COLUMNS + (COLUMNS - 1 - x);
            pix_bytes[idx] = pix_bytes[idx] ^ (8'h01 << (y % 8));
        endfunction

        function void note_command(logic [2:0] c, logic [7:0] px, logic [7:0] py,
                                   logic [7:0] len, logic [7:0] hgt, logic f);
            int x;
            int y;
            logic [7:0] rd;
            x = int'(px);
            y = int'(py);
            rd = 8'h00;
            case (c)
                CMD_WRITE_PIXEL:  paint_pixel(x, y, f);
                CMD_INVERT_PIXEL: flip_pixel(x, y);
                CMD_HLINE:        for (int i = 0; i < int'(len); i++) paint_pixel(x + i, y, f);
                CMD_VLINE:        for (int i = 0; i < int'(len); i++) paint_pixel(x, y + i, f);
                CMD_INVERT_RECT: begin
                    for (int i = 0; i < int'(len); i++)
                        for (int j = 0; j < int'(hgt); j++)
                            flip_pixel(x + i, y + j);
                end
                CMD_CLEAR:        foreach (pix_bytes[k]) pix_bytes[k] = 8'h00;
                CMD_READ_BYTE: begin
                    if (x < COLUMNS && y < ROWS) rd = pix_bytes[(y / 8) * COLUMNS + x];
                end
                default: ;
            endcase
            byte_q.push_back(rd);
        endfunction

        function void check_byte(logic [7:0] got);
            logic [7:0] want;
            if (byte_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %02h",
                         $time, got);
                errors++;
                return;
            end
            want = byte_q.pop_front();
            if (got !== want) begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [2:0] i_cmd = 3'd0;
    logic [7:0] i_pos_x = 8'd0;
    logic [7:0] i_pos_y = 8'd0;
    logic [7:0] i_span_len = 8'd0;
    logic [7:0] i_span_height = 8'd0;
    logic       i_fill = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_read_data;

    fb_scoreboard sb = new();
    bit calm_tail = 1'b0;
    int push_idle_mode = 0;
    int pop_idle_mode = 0;

    mono_page_framebuffer_draw dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_span_len   (i_span_len),
        .i_span_height(i_span_height),
        .i_fill       (i_fill),
        .empty        (empty),
        .pop          (pop),
        .o_read_data  (o_read_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Holds the beat on the ports until the block takes it; push stays high afterwards.
    task automatic send_cmd(logic [2:0] c, logic [7:0] x, logic [7:0] y,
                            logic [7:0] len, logic [7:0] hgt, logic f);
        @(negedge i_clk);
        push = 1'b1;
        i_cmd = c;
        i_pos_x = x;
        i_pos_y = y;
        i_span_len = len;
        i_span_height = hgt;
        i_fill = f;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        sb.note_command(c, x, y, len, hgt, f);
    endtask

    task automatic pause_push(int n);
        @(negedge i_clk);
        push = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_coord(int span);
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, span - 1));
    endfunction

    task automatic send_random_cmd();
        int r;
        logic [2:0] c;
        logic [7:0] len;
        logic [7:0] hgt;
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 16));
        hgt = 8'($urandom_range(0, 255));
        if (r < 15)      c = CMD_WRITE_PIXEL;
        else if (r < 25) c = CMD_INVERT_PIXEL;
        else if (r < 37) c = CMD_HLINE;
        else if (r < 49) c = CMD_VLINE;
        else if (r < 57) c = CMD_INVERT_RECT;
        else if (r < 59) c = CMD_CLEAR;
        else if (r < 98) c = CMD_READ_BYTE;
        else             c = CMD_UNUSED;
        // Rectangles cost a store read and a write per pixel, so large ones stay rare.
        if (c == CMD_INVERT_RECT) begin
            if ($urandom_range(0, 49) == 0) begin
                len = 8'($urandom_range(0, 255));
                hgt = 8'($urandom_range(0, 255));
            end else begin
                len = 8'($urandom_range(0, 8));
                hgt = 8'($urandom_range(0, 8));
            end
        end
        send_cmd(c, pick_coord(COLUMNS), pick_coord(ROWS), len, hgt,
                 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int stall_left;
        int beats;
        bit held_off;
        stall_left = 0;
        beats = 0;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            // One long hold-off lets the block fill up and stall its input.
            if (!held_off && beats >= 250) begin
                held_off = 1'b1;
                stall_left = 400;
            end else if (stall_left == 0 && !calm_tail && pop_idle_mode != 0
                         && $urandom_range(0, 7 * pop_idle_mode) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                pop = 1'b0;
                stall_left--;
            end else begin
                pop = 1'b1;
            end
            @(posedge i_clk);
            if (pop && empty === 1'b0) begin
                sb.check_byte(o_read_data);
                beats++;
            end
        end
    end

    initial begin
        int drain;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);

        send_cmd(CMD_WRITE_PIXEL,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        send_cmd(CMD_WRITE_PIXEL,  8'd127, 8'd63,  8'd0,   8'd0,   1'b1);
        send_cmd(CMD_READ_BYTE,    8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_READ_BYTE,    8'd127, 8'd56,  8'd0,   8'd0,   1'b0);
        send_cmd(CMD_INVERT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_READ_BYTE,    8'd127, 8'd0,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_WRITE_PIXEL,  8'd128, 8'd0,   8'd0,   8'd0,   1'b1);
        send_cmd(CMD_WRITE_PIXEL,  8'd0,   8'd64,  8'd0,   8'd0,   1'b1);
        send_cmd(CMD_WRITE_PIXEL,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_cmd(CMD_HLINE,        8'd100, 8'd5,   8'd255, 8'd0,   1'b1);
        send_cmd(CMD_READ_BYTE,    8'd127, 8'd5,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_VLINE,        8'd3,   8'd60,  8'd255, 8'd0,   1'b1);
        send_cmd(CMD_HLINE,        8'd0,   8'd8,   8'd0,   8'd0,   1'b1);
        send_cmd(CMD_VLINE,        8'd9,   8'd8,   8'd0,   8'd0,   1'b1);
        send_cmd(CMD_INVERT_RECT,  8'd0,   8'd0,   8'd128, 8'd64,  1'b0);
        send_cmd(CMD_READ_BYTE,    8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_INVERT_RECT,  8'd120, 8'd60,  8'd255, 8'd255, 1'b0);
        send_cmd(CMD_INVERT_RECT,  8'd10,  8'd10,  8'd5,   8'd0,   1'b0);
        send_cmd(CMD_READ_BYTE,    8'd128, 8'd0,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_READ_BYTE,    8'd0,   8'd64,  8'd0,   8'd0,   1'b0);
        send_cmd(CMD_UNUSED,       8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_cmd(CMD_WRITE_PIXEL,  8'd127, 8'd63,  8'd0,   8'd0,   1'b0);
        send_cmd(CMD_READ_BYTE,    8'd7,   8'd63,  8'd0,   8'd0,   1'b0);
        send_cmd(CMD_CLEAR,        8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_cmd(CMD_READ_BYTE,    8'd127, 8'd5,   8'd0,   8'd0,   1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Idling density changes every so often, and a stretch may have none.
            if (n % 150 == 0) begin
                push_idle_mode = $urandom_range(0, 3);
                pop_idle_mode = $urandom_range(0, 3);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
            if (!calm_tail && push_idle_mode != 0
                && $urandom_range(0, 5 * push_idle_mode) == 0)
                pause_push($urandom_range(1, 12));
            send_random_cmd();
        end
        @(negedge i_clk);
        push = 1'b0;

        while (sb.byte_q.size() != 0) @(posedge i_clk);
        // Every command yields a beat, so a short quiet period catches strays.
        for (drain = 0; drain < 64; drain++) @(posedge i_clk);
        if (sb.byte_q.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, sb.byte_q.size());
            sb.errors++;
        end

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> mono_page_framebuffer_draw.f
rtl/core/mpfb_pkg.sv
rtl/core/mpfb_ram.sv
rtl/core/mpfb_front.sv
rtl/core/mpfb_back.sv
rtl/core/mono_page_framebuffer_draw.sv
dv/tb_mono_page_framebuffer_draw.sv
